>>> hw/rtl/rdq_pkg.sv
// Shared types, constants and codes for the reversible double-ended queue.
`default_nettype none

package rdq_pkg;

   // Storage geometry.
   localparam int unsigned DEPTH       = 16;
   localparam int unsigned VALUE_WIDTH = 64;
   localparam int unsigned PTR_W       = $clog2(DEPTH);
   localparam int unsigned CNT_W       = $clog2(DEPTH + 1);

   // Fixed field widths of the transaction payloads.
   localparam int unsigned OPCODE_W      = 3;
   localparam int unsigned VALUE_FIELD_W = 64;
   localparam int unsigned ENTRY_COUNT_W = 5;
   localparam int unsigned ERROR_CODE_W  = 2;

   // Operation codes carried by a request.
   typedef enum logic [OPCODE_W-1:0] {
      OP_NONE       = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_PUSH_BACK  = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_POP_BACK   = 3'd4,
      OP_REVERSE    = 3'd5
   } op_type;

   // Error codes returned with every response.
   typedef enum logic [ERROR_CODE_W-1:0] {
      ERR_OK    = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   // Request payload.
   typedef struct packed {
      logic [OPCODE_W-1:0]      opcode;
      logic [VALUE_FIELD_W-1:0] value_in;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [VALUE_FIELD_W-1:0] front_value;
      logic [VALUE_FIELD_W-1:0] back_value;
      logic [ENTRY_COUNT_W-1:0] entry_count;
      logic                     is_empty;
      logic [ERROR_CODE_W-1:0]  error_code;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;
      logic load;
   } cmd_type;

   // Status from the datapath.
   typedef struct packed {
      logic [CNT_W-1:0] count;
   } status_type;

endpackage

`default_nettype wire

>>> hw/rtl/rdq_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module rdq_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr_a,
   output logic      [WIDTH-1:0]  rd_data_a,
   input  wire logic [ADDR_W-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]  rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read ports.
   always_ff @(posedge clock) begin
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

`default_nettype wire

>>> hw/rtl/rdq_ctrl.sv
// Controller state machine that sequences one transaction at a time.
`default_nettype none

module rdq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rdq_pkg::cmd_type      cmd
);
   import rdq_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.exec = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            // Load the output register once it is empty or being drained.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rdq_dpath.sv
// Datapath: pointers, count, direction bit, ring store and response register.
`default_nettype none

module rdq_dpath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rdq_pkg::cmd_type cmd,
   input  wire rdq_pkg::req_type req_data,
   output rdq_pkg::rsp_type      rsp_data,
   output rdq_pkg::status_type   status
);
   import rdq_pkg::*;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rev_ff, rev_in;
   err_type          err_ff, err_in;
   rsp_type          rsp_ff, rsp_in;

   logic                   wr_en;
   logic [PTR_W-1:0]       wr_addr;
   logic [VALUE_WIDTH-1:0] head_rd, tail_rd;
   logic                   at_head, full, empty;

   // Wrapping pointer steps.
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(DEPTH - 1) : p - PTR_W'(1);
   endfunction

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   // Queue update for an accepted transaction.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      err_in   = err_ff;
      wr_en    = 1'b0;
      wr_addr  = head_ff;
      at_head  = 1'b0;
      if (cmd.exec) begin
         err_in = ERR_OK;
         unique case (op_type'(req_data.opcode))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
               // Front maps to the physical head unless the direction is flipped.
               at_head = (op_type'(req_data.opcode) == OP_PUSH_FRONT) ^ rev_ff;
               if (full) begin
                  err_in = ERR_FULL;
               end else begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (empty) begin
                     tail_in = head_ff;
                     wr_addr = head_ff;
                  end else if (at_head) begin
                     head_in = ptr_dec(head_ff);
                     wr_addr = ptr_dec(head_ff);
                  end else begin
                     tail_in = ptr_inc(tail_ff);
                     wr_addr = ptr_inc(tail_ff);
                  end
               end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
               at_head = (op_type'(req_data.opcode) == OP_POP_FRONT) ^ rev_ff;
               if (empty) begin
                  err_in = ERR_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
                  if (count_ff == CNT_W'(1)) begin
                     tail_in = head_ff;
                  end else if (at_head) begin
                     head_in = ptr_inc(head_ff);
                  end else begin
                     tail_in = ptr_dec(tail_ff);
                  end
               end
            end
            OP_REVERSE: begin
               rev_in = ~rev_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         err_ff   <= ERR_OK;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
         err_ff   <= err_in;
      end
   end

   // Ring store, read continuously at both ends.
   rdq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (req_data.value_in[VALUE_WIDTH-1:0]),
      .rd_addr_a (head_ff),
      .rd_data_a (head_rd),
      .rd_addr_b (tail_ff),
      .rd_data_b (tail_rd)
   );

   // Response assembly; empty queues report zero values.
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load) begin
         rsp_in.front_value = '0;
         rsp_in.back_value  = '0;
         if (!empty) begin
            rsp_in.front_value = VALUE_FIELD_W'(rev_ff ? tail_rd : head_rd);
            rsp_in.back_value  = VALUE_FIELD_W'(rev_ff ? head_rd : tail_rd);
         end
         rsp_in.entry_count = ENTRY_COUNT_W'(count_ff);
         rsp_in.is_empty    = empty;
         rsp_in.error_code  = err_ff;
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data     = rsp_ff;
   assign status.count = count_ff;

endmodule

`default_nettype wire

>>> hw/rtl/reversible_deque.sv
// Top level of the reversible double-ended queue.
// After acceptance a request passes through the read and load states; its response is then
// registered once the output register is free. Only one transaction is in flight at a time.
// The next request is taken while a finished response still waits in the output register.
// Reset is synchronous and active high: pointers, count, direction and handshake state clear.
// The ring store itself is not cleared; only occupied entries are ever reported.
`default_nettype none

module reversible_deque (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire rdq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rdq_pkg::rsp_type      rsp_data
);
   import rdq_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing.
   rdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // Queue state and storage.
   rdq_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .status   (status)
   );

   // The stored count never exceeds the depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      status.count <= CNT_W'(DEPTH))
      else $error("stored count exceeds depth");

   // One transaction at a time: no new request right after an acceptance.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while another is in flight");

   // An empty response carries zero values and a zero count.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_empty) |->
         (rsp_data.front_value == '0 && rsp_data.back_value == '0 &&
          rsp_data.entry_count == '0))
      else $error("empty response with nonzero fields");

   // A rejected push is only reported when the queue is full.
   a_full_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code == ERR_FULL) |->
         (rsp_data.entry_count == ENTRY_COUNT_W'(DEPTH)))
      else $error("full error reported on a queue that is not full");

endmodule

`default_nettype wire

>>> tb/sv/reversible_deque_tb.sv
// Self-checking testbench for the reversible double-ended queue.
`default_nettype none

module reversible_deque_tb;

   import rdq_pkg::*;

   // Opcodes outside the defined set; the block treats them as no operation.
   localparam logic [OPCODE_W-1:0] OP_SPARE_SIX   = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_SPARE_SEVEN = 3'd7;

   // Only the low VALUE_WIDTH bits of a pushed word are kept.
   localparam logic [VALUE_FIELD_W-1:0] VALUE_MASK =
      {VALUE_FIELD_W{1'b1}} >> (VALUE_FIELD_W - VALUE_WIDTH);

   localparam int PHASES          = 4;
   localparam int RANDOM_PER_PHASE = 356;
   localparam int SETTLE_CYCLES   = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Requests waiting to be driven and responses predicted but not yet seen.
   req_type request_backlog[$];
   rsp_type predicted_rsp[$];

   // Idle and stall rates, in percent, for the current phase.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   // Shadow copy of the queue contents.
   logic [VALUE_FIELD_W-1:0] shadow_ring[DEPTH];
   logic [PTR_W-1:0]         shadow_head     = '0;
   logic [PTR_W-1:0]         shadow_tail     = '0;
   logic [CNT_W-1:0]         shadow_count    = '0;
   logic                     shadow_reversed = 1'b0;

   // Run statistics.
   int unsigned error_count    = 0;
   int unsigned accepted_count = 0;
   int unsigned checked_count  = 0;
   int unsigned full_refusals  = 0;
   int unsigned empty_refusals = 0;
   int unsigned reversals      = 0;
   int unsigned deepest_count  = 0;

   reversible_deque dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock with a period of two time units.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Advance the shadow queue by one request and return the response it should produce.
   function automatic rsp_type deque_step(req_type r);
      rsp_type                  o;
      err_type                  err;
      logic                     at_head;
      logic [VALUE_FIELD_W-1:0] word;
      logic [VALUE_FIELD_W-1:0] head_word;
      logic [VALUE_FIELD_W-1:0] tail_word;
      err     = ERR_OK;
      word    = r.value_in & VALUE_MASK;
      at_head = 1'b0;
      o       = '0;
      case (r.opcode)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            // Push front lands on the physical head unless the direction is flipped.
            at_head = (r.opcode == OP_PUSH_FRONT) ^ shadow_reversed;
            if (shadow_count >= DEPTH) begin
               err = ERR_FULL;
               full_refusals++;
            end else begin
               if (shadow_count == 0) begin
                  shadow_tail = shadow_head;
                  shadow_ring[shadow_head] = word;
               end else if (at_head) begin
                  shadow_head = (shadow_head == 0) ? PTR_W'(DEPTH - 1) : shadow_head - 1'b1;
                  shadow_ring[shadow_head] = word;
               end else begin
                  shadow_tail = (shadow_tail == PTR_W'(DEPTH - 1)) ? '0 : shadow_tail + 1'b1;
                  shadow_ring[shadow_tail] = word;
               end
               shadow_count++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            at_head = (r.opcode == OP_POP_FRONT) ^ shadow_reversed;
            if (shadow_count == 0) begin
               err = ERR_EMPTY;
               empty_refusals++;
            end else begin
               shadow_count--;
               if (shadow_count == 0)
                  shadow_tail = shadow_head;
               else if (at_head)
                  shadow_head = (shadow_head == PTR_W'(DEPTH - 1)) ? '0 : shadow_head + 1'b1;
               else
                  shadow_tail = (shadow_tail == 0) ? PTR_W'(DEPTH - 1) : shadow_tail - 1'b1;
            end
         end
         OP_REVERSE: begin
            shadow_reversed = ~shadow_reversed;
            reversals++;
         end
         default: begin
         end
      endcase
      // Only occupied entries are read; an empty queue reports zero at both ends.
      if (shadow_count != 0) begin
         head_word     = shadow_ring[shadow_head];
         tail_word     = shadow_ring[shadow_tail];
         o.front_value = shadow_reversed ? tail_word : head_word;
         o.back_value  = shadow_reversed ? head_word : tail_word;
      end
      o.entry_count = ENTRY_COUNT_W'(shadow_count);
      o.is_empty    = (shadow_count == 0);
      o.error_code  = err;
      if (shadow_count > deepest_count)
         deepest_count = 32'(shadow_count);
      return o;
   endfunction

   // Driver: on every accepted transaction record the prediction, then offer the next request.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_rsp.push_back(deque_step(req_data));
            accepted_count++;
         end
         if (!req_valid || req_ready) begin
            if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= request_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (actual !== expected) begin
         $error("%s mismatch: expected %0h, actual %0h", name, expected, actual);
         error_count++;
      end
   endtask

   // Monitor: stall the response channel at random and check every response transaction.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsp.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               exp_rsp = predicted_rsp.pop_front();
               check_field("front_value", exp_rsp.front_value, rsp_data.front_value);
               check_field("back_value", exp_rsp.back_value, rsp_data.back_value);
               check_field("entry_count", 64'(exp_rsp.entry_count), 64'(rsp_data.entry_count));
               check_field("is_empty", 64'(exp_rsp.is_empty), 64'(rsp_data.is_empty));
               check_field("error_code", 64'(exp_rsp.error_code), 64'(rsp_data.error_code));
               checked_count++;
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_request(logic [OPCODE_W-1:0] op, logic [VALUE_FIELD_W-1:0] word);
      req_type r;
      r.opcode   = op;
      r.value_in = word;
      request_backlog.push_back(r);
   endtask

   function automatic logic [VALUE_FIELD_W-1:0] random_word();
      int unsigned pick;
      pick = $urandom_range(15);
      if (pick == 0)
         return '0;
      if (pick == 1)
         return '1;
      return {$urandom, $urandom};
   endfunction

   // Edge cases from an empty queue up to a full one, refused pushes, then pops after a reversal.
   task automatic queue_directed();
      queue_request(OP_POP_FRONT, '1);
      queue_request(OP_POP_BACK, '0);
      queue_request(OP_REVERSE, '0);
      queue_request(OP_NONE, '1);
      queue_request(OP_SPARE_SIX, '1);
      queue_request(OP_SPARE_SEVEN, '0);
      queue_request(OP_REVERSE, '1);
      // First push goes into the empty queue; the rest wrap the pointers to full.
      queue_request(OP_PUSH_FRONT, '1);
      queue_request(OP_PUSH_BACK, '0);
      for (int i = 2; i < DEPTH; i++)
         queue_request((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                       (i % 3 == 0) ? {32{2'b10}} : (64'h1 << (i * 4)) | 64'(i));
      queue_request(OP_PUSH_FRONT, 64'h0123_4567_89ab_cdef);
      queue_request(OP_PUSH_BACK, {32{2'b01}});
      queue_request(OP_REVERSE, '0);
      queue_request(OP_POP_FRONT, '0);
      queue_request(OP_POP_BACK, '1);
   endtask

   // Random bursts that lean toward filling, draining or mixing the queue.
   task automatic queue_random(int unsigned count);
      int unsigned              burst_left;
      int unsigned              lean;
      int unsigned              roll;
      int unsigned              spare;
      logic [OPCODE_W-1:0]      op;
      burst_left = 0;
      lean       = 0;
      for (int unsigned n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 8);
            lean       = $urandom_range(2);
         end
         burst_left--;
         roll = $urandom_range(99);
         // Lean 0 fills, lean 1 drains, lean 2 keeps the two balanced.
         if (roll < 6) begin
            spare = $urandom_range(2);
            op = (spare == 0) ? OP_NONE : (spare == 1) ? OP_SPARE_SIX : OP_SPARE_SEVEN;
         end else if (roll < 12) begin
            op = OP_REVERSE;
         end else if ((lean == 0 && roll < 82) || (lean == 1 && roll < 30)
                      || (lean == 2 && roll < 56)) begin
            op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         end else begin
            op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
         end
         queue_request(op, random_word());
      end
   endtask

   // Stimulus sequencing: each phase sets its idle rates and runs until fully drained.
   initial begin
      int unsigned send_pct[PHASES];
      int unsigned recv_pct[PHASES];
      send_pct = '{0, 59, 0, 32};
      recv_pct = '{0, 0, 59, 32};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         @(negedge clock);
         send_idle_pct  = send_pct[p];
         recv_stall_pct = recv_pct[p];
         if (p == 0)
            queue_directed();
         queue_random(RANDOM_PER_PHASE);
         // The sender holds off here until every response of the phase has arrived.
         while (request_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0)
            @(negedge clock);
      end
      recv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (predicted_rsp.size() != 0) begin
         $error("%0d predicted responses never arrived", predicted_rsp.size());
         error_count++;
      end
      $display("Covered %0d requests and %0d checked responses over %0d idle phases, depth %0d.",
               accepted_count, checked_count, PHASES, deepest_count);
      $display("Pushes refused when full: %0d, pops refused when empty: %0d, reversals: %0d.",
               full_refusals, empty_refusals, reversals);
      if (error_count == 0)
         $display("[reversible_deque] OK");
      else
         $display("[reversible_deque] ERROR");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #400000;
      $display("[reversible_deque] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
hw/rtl/rdq_pkg.sv
hw/rtl/rdq_ram.sv
hw/rtl/rdq_ctrl.sv
hw/rtl/rdq_dpath.sv
hw/rtl/reversible_deque.sv
tb/sv/reversible_deque_tb.sv
